### rtl/intel_hex_record_parser_assert.svh
// Assertion macros shared by the Intel HEX record parser modules
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition on every clock edge out of reset
`define IHEX_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define IHEX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define IHEX_ASSERT(lbl, cond, msg)
`define IHEX_ASSERT_IMPL(lbl, ante, cons, msg)
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/ihex_pkg.sv
// Types, constants and the hex digit decoder for the Intel HEX record parser
package ihex_pkg;

  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] POS_MAX = '1;
  localparam logic [7:0] START_CHAR = 8'h3A;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    V_DATA    = 3'd0,
    V_EMPTY   = 3'd1,
    V_IGNORED = 3'd2,
    V_END     = 3'd3,
    V_ERROR   = 3'd4,
    V_NONE    = 3'd7
  } verdict_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] record_address;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  line_status;
    logic [6:0]  word_count;
  } result_t;

  // Handshake control between the input register and the result register
  typedef struct packed {
    logic go;
    logic res_vld;
  } stage_ctl_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f' both have low nibble 1..6
      d.value = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

### rtl/ihex_if.sv
// Valid/ready channel interfaces for characters in and parser results out
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] record_address;
  logic [6:0]  word_index;
  logic [15:0] word_value;
  logic [2:0]  line_status;
  logic [6:0]  word_count;

  modport source (output valid, output item_kind, output record_address, output word_index,
                  output word_value, output line_status, output word_count, input ready);
  modport sink   (input valid, input item_kind, input record_address, input word_index,
                  input word_value, input line_status, input word_count, output ready);
endinterface

### rtl/ihex_in_stage.sv
// Input register: captures one character word and holds it until the parser takes it
module ihex_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  ihex_in_if.sink     in_ch,
  input  logic        out_free,
  output logic        go,
  output logic [7:0]  char_q,
  output logic        eol_q
);
  import ihex_pkg::*;

  logic       vld_r;
  logic [7:0] char_r;
  logic       eol_r;
  logic       load;

  assign go          = vld_r & out_free;
  assign in_ch.ready = ~vld_r | go;
  assign load        = in_ch.valid & in_ch.ready;
  assign char_q      = char_r;
  assign eol_q       = eol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (go) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_ch.char_code;
      eol_r  <= in_ch.end_of_line;
    end
  end

endmodule

### rtl/ihex_core.sv
// Record field decoder: line state, checksum, word packing and line verdict
module ihex_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        char_code,
  input  logic              eol,
  output logic              res_vld,
  output ihex_pkg::result_t res
);
  import ihex_pkg::*;

`include "intel_hex_record_parser_assert.svh"

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      count_r, count_nxt;
  logic [15:0]     addr_r, addr_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [3:0]      high_r, high_nxt;
  logic [7:0]      low_r, low_nxt;
  logic [6:0]      words_r, words_nxt;
  verdict_t        verdict_r, verdict_nxt;

  hex_digit_t      dig;
  logic [7:0]      byte_val;
  logic [8:0]      k;
  logic [8:0]      data_end;
  logic [8:0]      data_off;
  verdict_t        st;

  assign dig      = hex_decode(char_code);
  assign byte_val = {high_r, dig.value};
  // byte index within the record: count, addr hi, addr lo, type, data...
  assign k        = pos_r[PosW-1:1] - 9'd1;
  assign data_end = 9'd4 + {1'b0, count_r};
  assign data_off = k - 9'd4;

  always_comb begin
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    addr_nxt    = addr_r;
    sum_nxt     = sum_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    words_nxt   = words_r;
    verdict_nxt = verdict_r;
    st          = V_NONE;
    res_vld     = 1'b0;
    res         = '0;

    if (fire) begin
      if (verdict_r == V_NONE) begin
        if (pos_r == '0) begin
          if (char_code != START_CHAR) verdict_nxt = V_ERROR;
        end else if (!dig.ok) begin
          verdict_nxt = V_ERROR;
        end else if (pos_r[0]) begin
          high_nxt = dig.value;
        end else begin
          sum_nxt = sum_r + byte_val;
          if (k == 9'd0) begin
            count_nxt = byte_val;
            if (byte_val == 8'd0) verdict_nxt = V_EMPTY;
          end else if (k == 9'd1) begin
            addr_nxt = {byte_val, 8'h00};
          end else if (k == 9'd2) begin
            addr_nxt = {addr_r[15:8], byte_val};
          end else if (k == 9'd3) begin
            if (byte_val > 8'd1)  verdict_nxt = V_IGNORED;
            else if (byte_val == 8'd1) verdict_nxt = V_END;
            else if (count_r[0])  verdict_nxt = V_ERROR;
          end else if (k < data_end) begin
            if (!data_off[0]) begin
              low_nxt = byte_val;
            end else begin
              words_nxt          = words_r + 7'd1;
              res_vld            = 1'b1;
              res.item_kind      = KIND_WORD;
              res.record_address = addr_r;
              res.word_index     = words_r;
              res.word_value     = {byte_val, low_r};
            end
          end else begin
            // checksum byte: whole record must sum to zero
            verdict_nxt = (sum_nxt == 8'd0) ? V_DATA : V_ERROR;
          end
        end
      end

      if (eol) begin
        if (pos_r == '0)              st = V_EMPTY;
        else if (verdict_nxt == V_NONE) st = V_ERROR;
        else                          st = verdict_nxt;
        // status replaces any word finished by the last character
        res_vld            = 1'b1;
        res                = '0;
        res.item_kind      = KIND_STATUS;
        res.line_status    = st;
        res.record_address = (st == V_DATA || st == V_IGNORED || st == V_END) ?
                             addr_nxt : 16'h0000;
        res.word_count     = (st == V_DATA) ? words_nxt : 7'd0;
        pos_nxt     = '0;
        count_nxt   = '0;
        addr_nxt    = '0;
        sum_nxt     = '0;
        high_nxt    = '0;
        low_nxt     = '0;
        words_nxt   = '0;
        verdict_nxt = V_NONE;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      count_r   <= '0;
      addr_r    <= '0;
      sum_r     <= '0;
      high_r    <= '0;
      low_r     <= '0;
      words_r   <= '0;
      verdict_r <= V_NONE;
    end else begin
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      addr_r    <= addr_nxt;
      sum_r     <= sum_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
      words_r   <= words_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  `IHEX_ASSERT_NEXT(a_eol_clears, fire && eol, pos_r == '0 && verdict_r == V_NONE && words_r == 7'd0, "line state not cleared after end of line")
  `IHEX_ASSERT(a_words_in_count, {words_r, 1'b0} <= count_r, "more words packed than the byte count allows")
  `IHEX_ASSERT_IMPL(a_word_needs_open, res_vld && res.item_kind == KIND_WORD, verdict_r == V_NONE && !eol, "word emitted after a verdict or on end of line")

endmodule

### rtl/ihex_out_stage.sv
// Result register: holds one result word until the receiver takes it
module ihex_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  ihex_pkg::stage_ctl_t ctl,
  input  ihex_pkg::result_t res,
  output logic              out_free,
  ihex_out_if.source        out_ch
);
  import ihex_pkg::*;

`include "intel_hex_record_parser_assert.svh"

  logic    vld_r;
  result_t res_r;
  logic    load;

  assign out_free = ~vld_r | out_ch.ready;
  assign load     = ctl.go & ctl.res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.item_kind      = res_r.item_kind;
  assign out_ch.record_address = res_r.record_address;
  assign out_ch.word_index     = res_r.word_index;
  assign out_ch.word_value     = res_r.word_value;
  assign out_ch.line_status    = res_r.line_status;
  assign out_ch.word_count     = res_r.word_count;

  `IHEX_ASSERT_IMPL(a_status_clean, vld_r && res_r.item_kind == KIND_STATUS, res_r.word_value == 16'h0000 && res_r.word_index == 7'd0, "status word carries word fields")
  `IHEX_ASSERT_IMPL(a_word_clean, vld_r && res_r.item_kind == KIND_WORD, res_r.line_status == 3'd0 && res_r.word_count == 7'd0, "data word carries status fields")

endmodule

### rtl/intel_hex_record_parser.sv
// Intel HEX record parser: one ASCII character in, data words and line status out
//
// in_ch, unless stalled, takes one character per cycle; end_of_line is set on a line's last.
// out_ch gives a data word (item_kind 0) for each completed pair of data bytes,
// with its address and index, and one status word (item_kind 1) per line:
// data, empty, ignored, end or error, with the word count for a data record.
// A character is accepted into the input register, then decoded into the result
// register, from which out_ch offers the result until the receiver takes it.
// The decode of a character is one step of the line state held in the core.
// A character that completes no word and ends no line gives no result.
// Reset (rst_n low at a clock edge) empties both registers and returns the line
// state to the start of a line.
// When the receiver holds ready low, the result register keeps its word, the
// input register takes at most one more character and then in_ch.ready drops until
// the result is taken.
module intel_hex_record_parser (
  input  logic         clk,
  input  logic         rst_n,
  ihex_in_if.sink      in_ch,
  ihex_out_if.source   out_ch
);
  import ihex_pkg::*;

  logic       out_free;
  logic       go;
  logic [7:0] char_q;
  logic       eol_q;
  logic       res_vld;
  result_t    res;
  stage_ctl_t ctl;

  assign ctl.go      = go;
  assign ctl.res_vld = res_vld;

  ihex_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .go       (go),
    .char_q   (char_q),
    .eol_q    (eol_q)
  );

  ihex_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (go),
    .char_code (char_q),
    .eol       (eol_q),
    .res_vld   (res_vld),
    .res       (res)
  );

  ihex_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

### dv/intel_hex_record_parser_tb.sv
// Testbench for the Intel HEX record parser: directed lines, then random records checked by a predictor
module intel_hex_record_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int RANDOM_ITEMS = 625;
  localparam int HOLD_CYCLES = 120;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ihex_in_if  in_ch ();
  ihex_out_if out_ch ();

  intel_hex_record_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Line state of the predictor
  logic [PosW-1:0] p_pos;
  logic [7:0]      p_count;
  logic [15:0]     p_addr;
  logic [7:0]      p_sum;
  logic [3:0]      p_hi;
  logic [7:0]      p_low;
  logic [6:0]      p_words;
  verdict_t        p_verdict;

  result_t    due_words[$];
  logic [7:0] line_buf[$];
  stim_row_t  dir_rows[24];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int mismatches;
  int quiet_cycles;

  function automatic void clear_line();
    p_pos     = '0;
    p_count   = '0;
    p_addr    = '0;
    p_sum     = '0;
    p_hi      = '0;
    p_low     = '0;
    p_words   = '0;
    p_verdict = V_NONE;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c, output bit ok);
    ok = 1'b1;
    if (c >= "0" && c <= "9") return 4'(c - 8'h30);
    if (c >= "A" && c <= "F") return 4'(c - 8'h41 + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - 8'h61 + 8'd10);
    ok = 1'b0;
    return 4'h0;
  endfunction

  function automatic result_t status_word(input logic [15:0] addr, input verdict_t st,
                                          input logic [6:0] cnt);
    result_t r;
    r = '0;
    r.item_kind      = KIND_STATUS;
    r.record_address = addr;
    r.line_status    = st;
    r.word_count     = cnt;
    return r;
  endfunction

  function automatic result_t data_word(input logic [15:0] addr, input logic [6:0] idx,
                                        input logic [15:0] val);
    result_t r;
    r = '0;
    r.item_kind      = KIND_WORD;
    r.record_address = addr;
    r.word_index     = idx;
    r.word_value     = val;
    return r;
  endfunction

  // Advance the line state by one character; return 1 when it yields a word
  function automatic bit parse_char(input logic [7:0] c, input logic eol, output result_t r);
    logic [3:0]  nib;
    logic [7:0]  b;
    bit          ok;
    bit          word_out;
    int          k;
    logic [6:0]  idx;
    logic [15:0] val;
    verdict_t    st;
    word_out = 1'b0;
    idx = '0;
    val = '0;
    r = '0;
    if (p_verdict == V_NONE) begin
      if (p_pos == '0) begin
        if (c != START_CHAR) p_verdict = V_ERROR;
      end else begin
        nib = hex_value(c, ok);
        if (!ok) begin
          p_verdict = V_ERROR;
        end else if (p_pos[0]) begin
          p_hi = nib;
        end else begin
          b = {p_hi, nib};
          k = int'(p_pos[PosW-1:1]) - 1;
          p_sum = p_sum + b;
          if (k == 0) begin
            p_count = b;
            if (b == 8'd0) p_verdict = V_EMPTY;
          end else if (k == 1) begin
            p_addr = {b, 8'h00};
          end else if (k == 2) begin
            p_addr[7:0] = b;
          end else if (k == 3) begin
            if (b > 8'd1) p_verdict = V_IGNORED;
            else if (b == 8'd1) p_verdict = V_END;
            else if (p_count[0]) p_verdict = V_ERROR;
          end else if (k < 4 + int'(p_count)) begin
            if (((k - 4) & 1) == 0) begin
              p_low = b;
            end else begin
              word_out = 1'b1;
              idx = p_words;
              val = {b, p_low};
              p_words = p_words + 7'd1;
            end
          end else if (p_sum == 8'd0) begin
            p_verdict = V_DATA;
          end else begin
            p_verdict = V_ERROR;
          end
        end
      end
    end
    if (eol) begin
      st = p_verdict;
      if (p_pos == '0) st = V_EMPTY;
      else if (st == V_NONE) st = V_ERROR;
      r = status_word((st == V_DATA || st == V_IGNORED || st == V_END) ? p_addr : 16'h0,
                      st, (st == V_DATA) ? p_words : 7'd0);
      clear_line();
      return 1'b1;
    end
    if (p_pos != POS_MAX) p_pos = p_pos + 1'b1;
    if (word_out) begin
      r = data_word(p_addr, idx, val);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_hex(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endfunction

  // Build one random line in line_buf; big gives a long, well-formed data record
  task automatic make_line(input bit big);
    int          kind;
    int          cnt;
    int          typ;
    int          n;
    int          mut;
    logic [15:0] addr;
    logic [7:0]  sum;
    logic [7:0]  b;
    bit          ok;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (!big && kind < 5) begin
      line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (!big && kind < 11) begin
      n = $urandom_range(2, 12);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    addr = 16'($urandom);
    typ = 0;
    cnt = 2 * $urandom_range(1, 8);
    if (big) begin
      cnt = 2 * $urandom_range(30, 40);
    end else if (kind < 18) begin
      cnt = 2 * $urandom_range(9, 24);
    end else if (kind < 26) begin
      typ = 1;
      cnt = $urandom_range(0, 6);
    end else if (kind < 34) begin
      typ = $urandom_range(2, 255);
      cnt = $urandom_range(0, 6);
    end else if (kind < 40) begin
      cnt = 2 * $urandom_range(0, 7) + 1;
    end else if (kind < 45) begin
      cnt = 0;
      typ = $urandom_range(0, 255);
    end
    line_buf.push_back(START_CHAR);
    sum = 8'(cnt) + addr[15:8] + addr[7:0] + 8'(typ);
    push_hex(8'(cnt));
    push_hex(addr[15:8]);
    push_hex(addr[7:0]);
    push_hex(8'(typ));
    repeat (cnt) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      push_hex(b);
    end
    b = 8'h00 - sum;
    if (!big && $urandom_range(0, 9) == 0) b = b ^ 8'($urandom_range(1, 255));
    push_hex(b);
    if (big) return;
    mut = $urandom_range(0, 99);
    if (mut < 6) begin
      do b = 8'($urandom_range(0, 255)); while (b == START_CHAR);
      line_buf[0] = b;
    end else if (mut < 14) begin
      n = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end else if (mut < 20) begin
      do begin
        b = 8'($urandom_range(0, 255));
        void'(hex_value(b, ok));
      end while (ok);
      line_buf[$urandom_range(1, line_buf.size() - 1)] = b;
    end else if (mut < 35) begin
      n = $urandom_range(1, 5);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Offer one character word and hold it until the parser takes it
  task automatic put_char(input logic [7:0] c, input logic eol);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= c;
    in_ch.end_of_line <= eol;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_line();
    result_t r;
    logic    eol;
    foreach (line_buf[i]) begin
      eol = (i == line_buf.size() - 1);
      if (parse_char(line_buf[i], eol, r)) due_words.push_back(r);
      put_char(line_buf[i], eol);
    end
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: expected kind %0d addr %h idx %0d val %h st %0d cnt %0d",
               what, $time, want.item_kind, want.record_address, want.word_index,
               want.word_value, want.line_status, want.word_count);
      $display("  got kind %0d addr %h idx %0d val %h st %0d cnt %0d",
               got.item_kind, got.record_address, got.word_index, got.word_value,
               got.line_status, got.word_count);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.item_kind      = out_ch.item_kind;
      got.record_address = out_ch.record_address;
      got.word_index     = out_ch.word_index;
      got.word_value     = out_ch.word_value;
      got.line_status    = out_ch.line_status;
      got.word_count     = out_ch.word_count;
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word", '0, got);
      end else begin
        want = due_words.pop_front();
        if (got.item_kind !== want.item_kind || got.record_address !== want.record_address ||
            got.word_index !== want.word_index || got.word_value !== want.word_value ||
            got.line_status !== want.line_status || got.word_count !== want.word_count)
          report_mismatch("wrong word", want, got);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    result_t r;
    int      random_sent;
    int      cur_phase;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_line = 1'b0;
    rst_n             = 1'b0;
    send_idle_pct     = 31;
    recv_idle_pct     = 48;
    hold_req          = 1'b0;
    mismatches        = 0;
    quiet_cycles      = 0;
    clear_line();

    dir_rows = '{
      '{":", 1'b1, 1'b1, status_word(16'h0000, V_EMPTY, 7'd0)},    // lone start char
      '{8'h00, 1'b1, 1'b1, status_word(16'h0000, V_EMPTY, 7'd0)},  // lone char of any kind
      '{8'hFF, 1'b0, 1'b0, '0},
      '{"0", 1'b1, 1'b1, status_word(16'h0000, V_ERROR, 7'd0)},    // bad start
      '{":", 1'b0, 1'b0, '0},
      '{"G", 1'b1, 1'b1, status_word(16'h0000, V_ERROR, 7'd0)},    // non-hex digit
      '{":", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{"0", 1'b1, 1'b1, status_word(16'h0000, V_EMPTY, 7'd0)},    // zero count
      '{":", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{"2", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0},
      '{"F", 1'b0, 1'b0, '0},
      '{"f", 1'b0, 1'b0, '0},
      '{"f", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b0, '0},
      '{"A", 1'b0, 1'b0, '0},
      '{"5", 1'b0, 1'b0, '0},
      '{"f", 1'b0, 1'b0, '0},
      '{"0", 1'b0, 1'b1, data_word(16'hFFFF, 7'd0, 16'hF0A5)},
      '{"6", 1'b0, 1'b0, '0},
      '{"B", 1'b1, 1'b1, status_word(16'hFFFF, V_DATA, 7'd1)}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (parse_char(dir_rows[i].ch, dir_rows[i].eol, r) || dir_rows[i].typed)
        due_words.push_back(dir_rows[i].typed ? dir_rows[i].res : r);
      put_char(dir_rows[i].ch, dir_rows[i].eol);
    end

    random_sent = 0;
    cur_phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent * 3 / RANDOM_ITEMS != cur_phase) begin
        cur_phase++;
        if (cur_phase == 1) begin
          send_idle_pct = 48;
          recv_idle_pct = 31;
          make_line(1'b1);
          send_line();
          random_sent += line_buf.size();
        end else begin
          // no idling; stall the receiver once so the parser backs up
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      end
      make_line(1'b0);
      send_line();
      random_sent += line_buf.size();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ihex_pkg.sv
rtl/ihex_if.sv
rtl/ihex_in_stage.sv
rtl/ihex_core.sv
rtl/ihex_out_stage.sv
rtl/intel_hex_record_parser.sv
dv/intel_hex_record_parser_tb.sv
